// ===== sv/rwrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwrt_pkg: shared types and constants of the read window request tracker
// Operation codes, result kinds, verdicts, entry states and the queue word.
// ----------------------------------------------------------------------------
package rwrt_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_REFILL = 2'd1;
    localparam logic [1:0] OP_REPLY  = 2'd2;
    localparam logic [1:0] OP_TAKE   = 2'd3;

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_ERROR   = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    localparam logic [31:0] EOF_CODE     = 32'd1;
    localparam logic [16:0] CHUNK_MAX    = 17'd65536;
    localparam logic [16:0] CHUNK_RESET  = 17'd32768;
    localparam logic [22:0] WINDOW_MAX   = 23'd4194304;
    localparam logic [22:0] WINDOW_RESET = 23'd1048576;
    localparam int          MAX_RESULTS  = 32;

    localparam logic [2:0] CFG_CHUNK  = 3'd0;
    localparam logic [2:0] CFG_WINDOW = 3'd1;
    localparam logic [2:0] CFG_START  = 3'd2;
    localparam logic [2:0] CFG_FSIZE  = 3'd3;

    // Request as decoded by the front end
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] request_id;
        logic        reply_kind;
        logic [31:0] status_code;
        logic [31:0] data_length;
    } cmd_t;

    // One result toward the output side
    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  issued_id;
        logic [63:0] read_offset;
        logic [16:0] byte_count;
        logic [1:0]  verdict;
        logic        finished;
        logic        last;
    } res_t;

endpackage : rwrt_pkg
`default_nettype wire

// ===== sv/read_window_request_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// read_window_request_tracker_unit: windowed read request tracker
// Issues pipelined read requests, matches replies, retires in issue order.
// ----------------------------------------------------------------------------
// A request passes a two-entry command queue into a ring sequencer. A reply
// passes the look and do states (an unknown identifier goes straight to the
// output state); a take passes look and do again per dropped failed entry;
// a start or refill issues each read, then waits on the single output register.
// Each result carries tlast on the final result of its request. No clearing
// pass is needed after reset.
module read_window_request_tracker_unit #(
    parameter int MAX_OUTSTANDING = 32,
    parameter int ID_BASE         = 256
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [103:0] s_tdata,   // request_id, reply_kind, status_code, data_length
    input  wire  [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,   // issued_id, read_offset, byte_count, verdict, finished
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,   // last
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [63:0]  cfg_data
);
    import rwrt_pkg::*;

    logic [16:0] chunk_reg;
    logic [22:0] window_reg;
    logic [63:0] start_reg, fsize_reg;
    logic        cmd_valid, cmd_pop;
    cmd_t        cmd;
    res_t        res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= CHUNK_RESET;
            window_reg <= WINDOW_RESET;
            start_reg  <= '0;
            fsize_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case ({1'b0, cfg_index})
                CFG_CHUNK:  chunk_reg  <= cfg_data[16:0];
                CFG_WINDOW: window_reg <= cfg_data[22:0];
                CFG_START:  start_reg  <= cfg_data;
                CFG_FSIZE:  fsize_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    rwrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata[97:0]),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    rwrt_back #(
        .MAX_OUTSTANDING (MAX_OUTSTANDING),
        .ID_BASE         (ID_BASE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd),
        .cfg_chunk  (chunk_reg),
        .cfg_window (window_reg),
        .cfg_start  (start_reg),
        .cfg_fsize  (fsize_reg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {3'd0, res.finished, res.verdict, res.byte_count,
                      res.read_offset, res.issued_id};

    // Checks
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid) else $error("command popped from empty queue");
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_NONE) |-> m_tlast)
        else $error("nothing-ready result not last");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && m_tvalid) |-> 1'b0) else $error("command taken with result held");

endmodule : read_window_request_tracker_unit
`default_nettype wire

// ===== sv/rwrt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwrt_front: input side and command queue
// Accepts requests, decodes the operation and buffers them in a short FIFO.
// ----------------------------------------------------------------------------
module rwrt_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [97:0]           s_tdata,
    input  wire  [1:0]            s_tuser,
    output logic                  cmd_valid,
    input  wire                   cmd_pop,
    output rwrt_pkg::cmd_t        cmd
);
    import rwrt_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       fifo_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       push;

    // Decode the bus word into a command
    always_comb
    begin
        in_cmd.op          = s_tuser;
        in_cmd.request_id  = s_tdata[31:0];
        in_cmd.reply_kind  = s_tdata[32];
        in_cmd.status_code = s_tdata[64:33];
        in_cmd.data_length = s_tdata[96:65];
    end

    assign s_tready  = (cnt_reg != 2'(DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule : rwrt_front
`default_nettype wire

// ===== sv/rwrt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwrt_back: request ring sequencer
// Executes start, refill, reply and take against the ring of outstanding reads.
// ----------------------------------------------------------------------------
module rwrt_back #(
    parameter int MAX_OUTSTANDING = 32,
    parameter int ID_BASE         = 256
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_pop,
    input  rwrt_pkg::cmd_t        cmd,
    input  wire  [16:0]           cfg_chunk,
    input  wire  [22:0]           cfg_window,
    input  wire  [63:0]           cfg_start,
    input  wire  [63:0]           cfg_fsize,
    output logic                  res_valid,
    input  wire                   res_ready,
    output rwrt_pkg::res_t        res
);
    import rwrt_pkg::*;

    localparam int SW = (MAX_OUTSTANDING > 1) ? $clog2(MAX_OUTSTANDING) : 1;
    localparam int FW = $clog2(MAX_OUTSTANDING + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REFILL = 3'd1;
    localparam logic [2:0] S_RLOOK  = 3'd2;
    localparam logic [2:0] S_RDO    = 3'd3;
    localparam logic [2:0] S_TLOOK  = 3'd4;
    localparam logic [2:0] S_TDO    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Ring memories
    logic [SW-1:0] ring_ident_mem [MAX_OUTSTANDING];
    logic [63:0]   ring_offset_mem [MAX_OUTSTANDING];
    logic [16:0]   ring_len_mem [MAX_OUTSTANDING];
    logic [1:0]    ring_status_mem [MAX_OUTSTANDING];
    logic [SW-1:0] id_slot_mem [MAX_OUTSTANDING];

    logic [MAX_OUTSTANDING-1:0] in_use_reg;
    logic [SW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;
    logic [63:0]   next_off_reg, furthest_reg, limit_reg;
    logic [22:0]   outst_reg;
    logic          end_reg, err_reg;
    logic [16:0]   chunk_reg;
    logic [2:0]    state_reg;
    logic [5:0]    nres_reg;
    logic [SW-1:0] idx_reg, slot_reg;
    logic          res_pend_reg;
    res_t          res_reg;
    logic          go_refill_reg;

    // Reply payload held once the request leaves the queue
    logic          cmd_kind_reg;
    logic [31:0]   cmd_code_reg;
    logic [31:0]   cmd_len_reg;

    // Ring entry read port (registered), at the head or at the replied slot
    logic [SW-1:0] rd_ident_reg;
    logic [63:0]   rd_off_reg;
    logic [16:0]   rd_len_reg;
    logic [1:0]    rd_status_reg;

    // Lowest free ident
    logic [SW-1:0] free_id;
    logic          free_any;
    always_comb
    begin
        free_id  = '0;
        free_any = 1'b0;
        for (int i = MAX_OUTSTANDING - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_id  = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
        wrap_inc = (32'(v) + 32'd1 >= 32'(MAX_OUTSTANDING)) ? '0 : v + SW'(1);
    endfunction

    logic [22:0] win_eff;
    assign win_eff = (cfg_window > WINDOW_MAX) ? WINDOW_MAX : cfg_window;

    logic can_issue;
    assign can_issue = (32'(nres_reg) < MAX_RESULTS) &&
                       (32'(fill_reg) < MAX_OUTSTANDING) &&
                       (outst_reg < win_eff) && !end_reg && !err_reg && free_any;

    // Reply ident check
    logic [31:0] rid_idx;
    logic        rid_ok;
    assign rid_idx = cmd.request_id - 32'(ID_BASE);
    assign rid_ok  = (cmd.request_id >= 32'(ID_BASE)) &&
                     (rid_idx < 32'(MAX_OUTSTANDING)) && in_use_reg[rid_idx[SW-1:0]];

    // Reply evaluation on the registered slot entry
    logic        r_fail, r_eof;
    logic [16:0] r_got;
    logic [63:0] r_fs, r_furth, r_limit;
    logic        r_end;
    always_comb
    begin
        r_fail = 1'b0;
        r_eof  = 1'b0;
        r_got  = '0;
        if (!cmd_kind_reg)
        begin
            if (cmd_len_reg > 32'(chunk_reg))
                r_fail = 1'b1;
            else
                r_got = cmd_len_reg[16:0];
        end
        else
        begin
            r_eof  = (cmd_code_reg == EOF_CODE);
            r_fail = 1'b1;
        end
        r_end = 1'b0;
        if ((r_fail && r_eof) || (!r_fail && r_got == '0))
        begin
            r_end = 1'b1;
            r_got = '0;
        end
        r_furth = furthest_reg;
        if (r_got != '0 && furthest_reg < rd_off_reg)
            r_furth = rd_off_reg;
        r_fs    = rd_off_reg + 64'(r_got);
        r_limit = limit_reg;
        if (r_got < chunk_reg && limit_reg > r_fs)
            r_limit = r_fs;
        if (r_furth > r_limit)
        begin
            r_end = 1'b1;
            r_got = '0;
        end
    end

    logic [63:0] mk_off;
    assign mk_off = 64'(ID_BASE);

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid && !res_pend_reg;
    assign res_valid = res_pend_reg;
    assign res       = res_reg;

    logic fin_now;
    assign fin_now = (end_reg || err_reg) && (fill_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            next_off_reg  <= '0;
            furthest_reg  <= '0;
            limit_reg     <= '0;
            outst_reg     <= '0;
            end_reg       <= 1'b0;
            err_reg       <= 1'b0;
            chunk_reg     <= CHUNK_RESET;
            state_reg     <= S_IDLE;
            nres_reg      <= '0;
            res_pend_reg  <= 1'b0;
            go_refill_reg <= 1'b0;
        end
        else
        begin
            if (res_pend_reg && res_ready)
                res_pend_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        nres_reg <= '0;
                        unique case (cmd.op)
                            OP_START:
                            begin
                                in_use_reg   <= '0;
                                head_reg     <= '0;
                                tail_reg     <= '0;
                                fill_reg     <= '0;
                                furthest_reg <= '0;
                                outst_reg    <= '0;
                                end_reg      <= 1'b0;
                                err_reg      <= 1'b0;
                                chunk_reg    <= (cfg_chunk == '0) ? 17'd1 :
                                                (cfg_chunk > CHUNK_MAX) ? CHUNK_MAX
                                                                        : cfg_chunk;
                                next_off_reg <= cfg_start;
                                limit_reg    <= cfg_fsize;
                                state_reg    <= S_REFILL;
                            end
                            OP_REFILL: state_reg <= S_REFILL;
                            OP_REPLY:
                            begin
                                if (!rid_ok)
                                begin
                                    res_reg <= '{KIND_VERDICT, 9'd0, 64'd0, 17'd0,
                                                 VERDICT_UNKNOWN, fin_now, 1'b1};
                                    res_pend_reg <= 1'b1;
                                    state_reg    <= S_OUT;
                                end
                                else
                                begin
                                    idx_reg   <= rid_idx[SW-1:0];
                                    state_reg <= S_RLOOK;
                                end
                            end
                            default: state_reg <= S_TLOOK;
                        endcase
                    end
                end
                // Issue one read, then wait in S_OUT before the next; hold result until the last is known
                S_REFILL:
                begin
                    if (!res_pend_reg || res_ready)
                    begin
                        if (can_issue)
                        begin
                            in_use_reg[free_id] <= 1'b1;
                            tail_reg     <= wrap_inc(tail_reg);
                            fill_reg     <= fill_reg + FW'(1);
                            next_off_reg <= next_off_reg + 64'(chunk_reg);
                            outst_reg    <= outst_reg + 23'(chunk_reg);
                            nres_reg     <= nres_reg + 6'd1;
                            res_reg      <= '{KIND_REQUEST,
                                              9'(mk_off + 64'(free_id)),
                                              next_off_reg, chunk_reg,
                                              VERDICT_OK, 1'b0, 1'b0};
                            go_refill_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            state_reg     <= S_IDLE;
                            go_refill_reg <= 1'b0;
                        end
                    end
                end
                S_RLOOK: state_reg <= S_RDO;
                S_RDO:
                begin
                    in_use_reg[idx_reg] <= 1'b0;
                    if (r_fail && !r_eof)
                    begin
                        err_reg <= 1'b1;
                        res_reg <= '{KIND_VERDICT, 9'(mk_off + 64'(idx_reg)), rd_off_reg,
                                     17'd0, VERDICT_ERROR,
                                     (fill_reg == '0), 1'b1};
                    end
                    else
                    begin
                        furthest_reg <= r_furth;
                        limit_reg    <= r_limit;
                        if (r_end)
                            end_reg <= 1'b1;
                        res_reg <= '{KIND_VERDICT, 9'(mk_off + 64'(idx_reg)), rd_off_reg,
                                     r_got, VERDICT_OK,
                                     ((end_reg || err_reg || r_end) && fill_reg == '0),
                                     1'b1};
                    end
                    res_pend_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_TLOOK: state_reg <= S_TDO;
                S_TDO:
                begin
                    if (fill_reg != '0 && rd_status_reg != ST_PENDING)
                    begin
                        head_reg  <= wrap_inc(head_reg);
                        fill_reg  <= fill_reg - FW'(1);
                        outst_reg <= (outst_reg >= 23'(chunk_reg)) ?
                                     outst_reg - 23'(chunk_reg) : 23'd0;
                        if (rd_status_reg == ST_DONE)
                        begin
                            res_reg <= '{KIND_DATA, 9'(mk_off + 64'(rd_ident_reg)),
                                         rd_off_reg, rd_len_reg, VERDICT_OK,
                                         ((end_reg || err_reg) && fill_reg == FW'(1)),
                                         1'b1};
                            res_pend_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end
                        else
                            state_reg <= S_TLOOK;
                    end
                    else
                    begin
                        res_reg <= '{KIND_NONE, 9'd0, 64'd0, 17'd0, VERDICT_OK,
                                     fin_now, 1'b1};
                        res_pend_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                // Wait for the output slot; a refill result gets last/finished here
                S_OUT:
                begin
                    if (go_refill_reg && !res_pend_reg)
                    begin
                        res_reg.last     <= !can_issue;
                        res_reg.finished <= fin_now;
                        res_pend_reg     <= 1'b1;
                        state_reg        <= S_REFILL;
                        if (!can_issue)
                        begin
                            go_refill_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (!go_refill_reg)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Ring writes and registered reads
    logic [SW-1:0] rd_addr;
    assign rd_addr = (state_reg == S_RLOOK) ? id_slot_mem[idx_reg] : head_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_kind_reg <= cmd.reply_kind;
            cmd_code_reg <= cmd.status_code;
            cmd_len_reg  <= cmd.data_length;
        end
        if (state_reg == S_REFILL && can_issue && (!res_pend_reg || res_ready))
        begin
            id_slot_mem[free_id]       <= tail_reg;
            ring_ident_mem[tail_reg]   <= free_id;
            ring_offset_mem[tail_reg]  <= next_off_reg;
            ring_len_mem[tail_reg]     <= '0;
            ring_status_mem[tail_reg]  <= ST_PENDING;
        end
        if (state_reg == S_RDO)
        begin
            ring_status_mem[slot_reg] <= (r_fail && !r_eof) ? ST_FAILED : ST_DONE;
            ring_len_mem[slot_reg]    <= (r_fail && !r_eof) ? 17'd0 : r_got;
        end
        if (state_reg == S_RLOOK)
            slot_reg <= id_slot_mem[idx_reg];
        rd_ident_reg  <= ring_ident_mem[rd_addr];
        rd_off_reg    <= ring_offset_mem[rd_addr];
        rd_len_reg    <= ring_len_mem[rd_addr];
        rd_status_reg <= ring_status_mem[rd_addr];
    end

endmodule : rwrt_back
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: read window request tracker check
// Drives start, refill, reply and take requests with random gaps and output
// stalls, predicts every result from an internal ring model and compares
// each returned result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import rwrt_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;   // request_id, reply_kind, status_code, data_length
    logic [1:0]    s_tuser;   // operation
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;   // issued_id, read_offset, byte_count, verdict, finished
    logic [1:0]    m_tuser;   // kind
    logic          m_tlast;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [63:0]   cfg_data;

    read_window_request_tracker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies
    logic [16:0] reg_chunk;
    logic [22:0] reg_window;
    logic [63:0] reg_start;
    logic [63:0] reg_fsize;

    // Tracker model state
    logic [4:0]  ring_id_m   [32];
    logic [63:0] ring_off_m  [32];
    logic [16:0] ring_len_m  [32];
    logic [1:0]  ring_st_m   [32];
    logic [4:0]  id_slot_m   [32];
    logic [31:0] id_busy;
    logic [4:0]  head_m, tail_m;
    int          fill_m;
    logic [63:0] next_off_m, furthest_m, limit_m;
    int          outst_m;
    logic        eof_m, err_m;
    logic [16:0] chunk_m;

    res_t        expected_results[$];
    int          mismatches;
    int          requests_sent;
    int          results_seen;
    bit          quiet;       // no gaps, no stalls

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic res_t make_res(logic [1:0] k, logic [8:0] id, logic [63:0] off,
                                      logic [16:0] cnt, logic [1:0] v);
        res_t r;
        r = '0;
        r.kind        = k;
        r.issued_id   = id;
        r.read_offset = off;
        r.byte_count  = cnt;
        r.verdict     = v;
        return r;
    endfunction

    function automatic void clear_ring();
        id_busy    = '0;
        head_m     = '0;
        tail_m     = '0;
        fill_m     = 0;
        next_off_m = '0;
        furthest_m = '0;
        limit_m    = '0;
        outst_m    = 0;
        eof_m      = 1'b0;
        err_m      = 1'b0;
    endfunction

    // Issue reads while the window, the ring and the flags allow
    function automatic void issue_reads(ref res_t outq[$]);
        int win;
        int id;
        win = (reg_window > WINDOW_MAX) ? int'(WINDOW_MAX) : int'(reg_window);
        while (outq.size() < MAX_RESULTS && fill_m < 32 && outst_m < win && !eof_m && !err_m)
        begin
            id = 0;
            while (id < 32 && id_busy[id])
                id++;
            if (id >= 32)
                break;
            id_busy[id]       = 1'b1;
            id_slot_m[id]     = tail_m;
            ring_id_m[tail_m] = id[4:0];
            ring_off_m[tail_m] = next_off_m;
            ring_len_m[tail_m] = '0;
            ring_st_m[tail_m] = ST_PENDING;
            tail_m            = tail_m + 5'd1;
            fill_m++;
            outq.push_back(make_res(KIND_REQUEST, 9'(256 + id), next_off_m, chunk_m,
                                    VERDICT_OK));
            next_off_m = next_off_m + 64'(chunk_m);
            outst_m    = outst_m + int'(chunk_m);
        end
    endfunction

    // Predict the results of one accepted request
    function automatic void track_request(logic [1:0] op, logic [31:0] rid, logic rk,
                                          logic [31:0] code, logic [31:0] dlen);
        res_t        outq[$];
        logic [31:0] idx;
        logic [4:0]  slot, h;
        logic        is_eof, failed, fin, dlv;
        logic [31:0] got;
        logic [63:0] fs;
        bit          done;
        case (op)
            OP_START:
            begin
                clear_ring();
                chunk_m    = (reg_chunk == 0) ? 17'd1 :
                             ((reg_chunk > CHUNK_MAX) ? CHUNK_MAX : reg_chunk);
                next_off_m = reg_start;
                limit_m    = reg_fsize;
                issue_reads(outq);
            end
            OP_REFILL:
                issue_reads(outq);
            OP_REPLY:
            begin
                idx = rid - 32'd256;
                if (rid < 32'd256 || idx >= 32'd32 || !id_busy[idx[4:0]])
                    outq.push_back(make_res(KIND_VERDICT, '0, '0, '0, VERDICT_UNKNOWN));
                else
                begin
                    id_busy[idx[4:0]] = 1'b0;
                    slot   = id_slot_m[idx[4:0]];
                    failed = 1'b0;
                    is_eof = 1'b0;
                    got    = '0;
                    if (!rk)
                    begin
                        if (dlen > 32'(chunk_m))
                            failed = 1'b1;
                        else
                            got = dlen;
                    end
                    else
                    begin
                        is_eof = (code == EOF_CODE);
                        failed = 1'b1;
                    end
                    done = 1'b0;
                    if ((failed && is_eof) || (!failed && got == 0))
                    begin
                        eof_m = 1'b1;
                        got   = '0;
                    end
                    else if (failed)
                    begin
                        err_m = 1'b1;
                        ring_st_m[slot]  = ST_FAILED;
                        ring_len_m[slot] = '0;
                        outq.push_back(make_res(KIND_VERDICT, 9'(256 + idx), ring_off_m[slot],
                                                '0, VERDICT_ERROR));
                        done = 1'b1;
                    end
                    if (!done)
                    begin
                        ring_st_m[slot] = ST_DONE;
                        if (got > 0 && furthest_m < ring_off_m[slot])
                            furthest_m = ring_off_m[slot];
                        if (got < 32'(chunk_m))
                        begin
                            fs = ring_off_m[slot] + 64'(got);
                            if (limit_m > fs)
                                limit_m = fs;
                        end
                        if (furthest_m > limit_m)
                        begin
                            eof_m = 1'b1;
                            got   = '0;
                        end
                        ring_len_m[slot] = got[16:0];
                        outq.push_back(make_res(KIND_VERDICT, 9'(256 + idx), ring_off_m[slot],
                                                got[16:0], VERDICT_OK));
                    end
                end
            end
            default:
            begin
                // retire finished entries in order, drop failed ones
                while (fill_m > 0 && ring_st_m[head_m] != ST_PENDING && outq.size() == 0)
                begin
                    h      = head_m;
                    dlv    = (ring_st_m[h] == ST_DONE);
                    head_m = head_m + 5'd1;
                    fill_m--;
                    outst_m = (outst_m >= int'(chunk_m)) ? outst_m - int'(chunk_m) : 0;
                    if (dlv)
                        outq.push_back(make_res(KIND_DATA, 9'(256 + ring_id_m[h]),
                                                ring_off_m[h], ring_len_m[h], VERDICT_OK));
                end
                if (outq.size() == 0)
                    outq.push_back(make_res(KIND_NONE, '0, '0, '0, VERDICT_OK));
            end
        endcase
        fin = (eof_m || err_m) && fill_m == 0;
        foreach (outq[k])
        begin
            outq[k].finished = fin;
            outq[k].last     = (k == outq.size() - 1);
            expected_results.push_back(outq[k]);
        end
    endfunction

    // Random gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Send one request and predict its results at acceptance
    task automatic send_request(logic [1:0] op, logic [31:0] rid, logic rk,
                                logic [31:0] code, logic [31:0] dlen);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, dlen, code, rk, rid};
        do
            @(posedge clk);
        while (!s_tready);
        track_request(op, rid, rk, code, dlen);
        requests_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CHUNK:  reg_chunk  = value[16:0];
            CFG_WINDOW: reg_window = value[22:0];
            CFG_START:  reg_start  = value;
            default:    reg_fsize  = value;
        endcase
    endtask

    // Let every expected result arrive, then wait idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_regs(logic [63:0] ch, logic [63:0] win, logic [63:0] so,
                            logic [63:0] fsz);
        drain();
        write_reg(CFG_CHUNK, ch);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_START, so);
        write_reg(CFG_FSIZE, fsz);
    endtask

    task automatic send_op(logic [1:0] op);
        send_request(op, $urandom, 1'($urandom), $urandom, $urandom);
    endtask

    task automatic send_data(int id, logic [31:0] len);
        send_request(OP_REPLY, 32'(256 + id), 1'b0, $urandom, len);
    endtask

    task automatic send_status(int id, logic [31:0] code);
        send_request(OP_REPLY, 32'(256 + id), 1'b1, code, $urandom);
    endtask

    function automatic int pick_busy();
        int s;
        s = $urandom_range(31);
        for (int k = 0; k < 32; k++)
            if (id_busy[(s + k) % 32])
                return (s + k) % 32;
        return -1;
    endfunction

    // Reset values, every reply class, and unknown identifiers
    task automatic test_directed();
        send_op(OP_START);
        send_op(OP_TAKE);
        send_data(0, 32'd32768);
        send_data(1, 32'd100);
        send_status(2, EOF_CODE);
        send_status(3, 32'd5);
        send_status(4, 32'd0);
        send_data(5, 32'd32769);
        send_data(6, 32'd0);
        send_request(OP_REPLY, 32'd300, 1'b0, '0, '0);
        send_request(OP_REPLY, 32'd256, 1'b0, '0, '0);
        send_request(OP_REPLY, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_REPLY, 32'd255, 1'b0, '0, '0);
        repeat (4) send_op(OP_TAKE);
        send_op(OP_REFILL);
    endtask

    // Out-of-range registers and offset wrap
    task automatic test_extremes();
        set_regs(64'd0, 64'h7F_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, '1);
        send_op(OP_START);
        send_data(0, 32'd1);
        send_op(OP_TAKE);
        send_op(OP_REFILL);
        set_regs(64'h1_FFFF, 64'd1, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_8000);
        send_op(OP_START);
        send_data(0, 32'd65536);
        send_op(OP_TAKE);
        send_op(OP_REFILL);
        send_data(1, 32'd65536);
    endtask

    // Random phases: mostly well-formed replies and takes, some noise
    task automatic test_random(int phases, int per_phase);
        int r, id;
        logic [63:0] so;
        for (int p = 0; p < phases; p++)
        begin
            so = {$urandom, $urandom};
            quiet = (p % 4 == 3);
            set_regs(($urandom_range(9) < 7) ? 64'($urandom_range(64, 1)) : 64'($urandom),
                     ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(2000, 1)),
                     so,
                     ($urandom_range(2) == 0) ? so + 64'($urandom_range(3000)) :
                                                {$urandom, $urandom});
            send_op(OP_START);
            for (int i = 0; i < per_phase; i++)
            begin
                r  = $urandom_range(99);
                id = pick_busy();
                if (r < 50 && id >= 0)
                begin
                    r = $urandom_range(99);
                    if (r < 60)
                        send_data(id, 32'(chunk_m));
                    else if (r < 75)
                        send_data(id, $urandom_range(int'(chunk_m), 0));
                    else if (r < 80)
                        send_data(id, 32'($urandom_range(int'(chunk_m) + 4, int'(chunk_m) + 1)));
                    else if (r < 85)
                        send_data(id, $urandom);
                    else if (r < 92)
                        send_status(id, EOF_CODE);
                    else
                        send_status(id, $urandom);
                end
                else if (r < 56)
                    send_request(OP_REPLY, ($urandom_range(1) ? $urandom :
                                 32'($urandom_range(300, 250))), 1'($urandom), $urandom,
                                 $urandom);
                else if (r < 82)
                    send_op(OP_TAKE);
                else if (r < 95 || (fill_m != 0 && !eof_m && !err_m))
                    send_op(OP_REFILL);
                else
                    send_op(OP_START);
            end
        end
    endtask

    // Output stalls
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            case ($urandom_range(99)) inside
                [0:19]:  stall_left <= $urandom_range(3, 1);
                [20:22]: stall_left <= $urandom_range(40, 10);
                default: stall_left <= 0;
            endcase
        end
    end

    // Result checker
    res_t got_res, want_res;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got_res             = '0;
            got_res.kind        = m_tuser;
            got_res.issued_id   = m_tdata[8:0];
            got_res.read_offset = m_tdata[72:9];
            got_res.byte_count  = m_tdata[89:73];
            got_res.verdict     = m_tdata[91:90];
            got_res.finished    = m_tdata[92];
            got_res.last        = m_tlast;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d id %0d off %h cnt %0d",
                             got_res.kind, got_res.issued_id, got_res.read_offset,
                             got_res.byte_count);
            end
            else
            begin
                want_res = expected_results.pop_front();
                if (got_res != want_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected kind %0d id %0d off %h cnt %0d verd %0d fin %0d last %0d",
                                 want_res.kind, want_res.issued_id, want_res.read_offset,
                                 want_res.byte_count, want_res.verdict, want_res.finished,
                                 want_res.last);
                        $display("  actual   kind %0d id %0d off %h cnt %0d verd %0d fin %0d last %0d",
                                 got_res.kind, got_res.issued_id, got_res.read_offset,
                                 got_res.byte_count, got_res.verdict, got_res.finished,
                                 got_res.last);
                    end
                end
            end
        end
    end

    // Run-time limit
    initial
    begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet         = 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        results_seen  = 0;
        reg_chunk     = CHUNK_RESET;
        reg_window    = WINDOW_RESET;
        reg_start     = '0;
        reg_fsize     = '0;
        chunk_m       = CHUNK_RESET;
        clear_ring();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extremes();
        test_random(8, 48);
        drain();

        $display("covered %0d requests and %0d results over directed and random phases",
                 requests_sent, results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== read_window_request_tracker_unit.f =====
sv/rwrt_pkg.sv
sv/rwrt_front.sv
sv/rwrt_back.sv
sv/read_window_request_tracker_unit.sv
dv/testbench.sv
